FILE: rtl/wifi_scan_reply_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Wi-Fi scan reply parser
// Shared assertion forms that use the clock and reset of the top level.
// ----------------------------------------------------------------------------
`ifndef WIFI_SCAN_REPLY_PARSER_TOP_MACROS_SVH
`define WIFI_SCAN_REPLY_PARSER_TOP_MACROS_SVH

// Generic form with an explicit clock and active-low reset.
`define WSRP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wsrp assertion failed");

// Form on the standard clock and reset names.
`define WSRP_ASSERT_STD(name, prop) `WSRP_ASSERT(name, clk_i, rst_ni, prop)

`endif

FILE: rtl/wsrp_pkg.sv
// ----------------------------------------------------------------------------
// Wi-Fi scan reply parser package
// Types, codes and character constants shared by the parser modules.
// ----------------------------------------------------------------------------
package wsrp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_JUDGE,
    ST_HDR,
    ST_CHAR_RD,
    ST_CHAR,
    ST_ONE
  } state_e;

  typedef enum logic [2:0] {
    PH_SP,
    PH_SIG,
    PH_SEC,
    PH_REST,
    PH_FAIL
  } phase_e;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [2:0] KIND_HDR     = 3'd0;
  localparam logic [2:0] KIND_SSID    = 3'd1;
  localparam logic [2:0] KIND_BSSID   = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;
  localparam logic [2:0] KIND_TIMEOUT = 3'd5;

  localparam int TIMER_W = 20;
  localparam int MAX_W   = 8;
  localparam int CFG_W   = 20;
  localparam int CNT_W   = 16;
  localparam int SLEN_W  = 6;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_MAX     = 1'b1;

  localparam logic [TIMER_W-1:0] TIMER_TOP   = '1;
  localparam logic [CNT_W-1:0]   CNT_TOP     = '1;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST = 20'd18000;
  localparam logic [MAX_W-1:0]   MAX_RST     = 8'd20;

  localparam int SSID_MAX    = 32;
  localparam int BSSID_CHARS = 17;
  localparam int REST_MIN    = 19;
  localparam logic [7:0] RSSI_OFFSET = 8'd100;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic logic [7:0] prefix_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "+";
      3'd1: c = "Q";
      3'd2: c = "W";
      3'd3: c = "S";
      3'd4: c = "C";
      3'd5: c = "A";
      3'd6: c = "N";
      default: c = ":";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ok_char(input logic i);
    return i ? 8'h4B : 8'h4F;
  endfunction

  function automatic logic [7:0] error_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "E";
      3'd1: c = "R";
      3'd2: c = "R";
      3'd3: c = "O";
      default: c = "R";
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/wsrp_line_mem.sv
// ----------------------------------------------------------------------------
// Line memory
// One write port and one registered read port holding the current line.
// ----------------------------------------------------------------------------
module wsrp_line_mem #(
  parameter int DEPTH = 127,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wsrp_engine.sv
// ----------------------------------------------------------------------------
// Parser engine
// Builds lines in the line memory, walks a finished line to judge it and
// streams the resulting records through a one-entry output register.
// ----------------------------------------------------------------------------
module wsrp_engine #(
  parameter int LINE_MAX = 128,
  parameter int AW       = 7,
  parameter int LW       = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [wsrp_pkg::TIMER_W-1:0]  scan_timeout_i,
  input  logic [wsrp_pkg::MAX_W-1:0]    max_entries_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [7:0]                    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [7:0]                    mem_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    kind_o,
  output logic [7:0]                    data_byte_o,
  output logic signed [7:0]             rssi_dbm_o,
  output logic [7:0]                    security_o,
  output logic [wsrp_pkg::CNT_W-1:0]    ap_index_o,
  output logic [wsrp_pkg::SLEN_W-1:0]   ssid_length_o,
  output logic                          last_o
);

  import wsrp_pkg::*;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  logic               active_q, active_d;
  logic [LW-1:0]      line_len_q, line_len_d;
  logic [LW-1:0]      stored_q, stored_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [LW-1:0]      idx_q, idx_d;
  logic [LW-1:0]      len_q, len_d;
  logic               pfx_q, pfx_d;
  logic               ok_q, ok_d;
  logic               err_q, err_d;
  logic [7:0]         sig_q, sig_d;
  logic [7:0]         sec_q, sec_d;
  logic [LW-1:0]      p_q, p_d;
  logic [LW-1:0]      lc_q, lc_d;
  logic               found_q, found_d;
  logic [SLEN_W-1:0]  slen_q, slen_d;
  logic [7:0]         rssi_q, rssi_d;
  logic [CNT_W-1:0]   rec_idx_q, rec_idx_d;
  logic [AW-1:0]      em_addr_q, em_addr_d;
  logic [SLEN_W-1:0]  em_cnt_q, em_cnt_d;
  logic               em_ssid_q, em_ssid_d;
  logic [2:0]         one_kind_q, one_kind_d;

  logic               ov_q, ov_d;
  logic [2:0]         o_kind_q, o_kind_d;
  logic [7:0]         o_data_q, o_data_d;
  logic [7:0]         o_rssi_q, o_rssi_d;
  logic [7:0]         o_sec_q, o_sec_d;
  logic [CNT_W-1:0]   o_idx_q, o_idx_d;
  logic [SLEN_W-1:0]  o_slen_q, o_slen_d;
  logic               o_last_q, o_last_d;

  logic               accept;
  logic               slot_free;
  logic [TIMER_W-1:0] timer_inc;
  logic [7:0]         rb;
  logic               is_digit;
  logic [7:0]         digit;
  logic [7:0]         sig_next;
  logic [7:0]         sec_next;
  logic               rec_ok;
  logic [LW-1:0]      ssid_raw;
  logic [LW:0]        lc_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !ov_q || out_ready_i;
  assign timer_inc  = (timer_q == TIMER_TOP) ? timer_q : timer_q + 1'b1;
  assign rb         = mem_rdata_i;
  assign is_digit   = (rb >= CH_ZERO) && (rb <= CH_NINE);
  assign digit      = rb - CH_ZERO;
  assign sig_next   = {sig_q[4:0], 3'b000} + {sig_q[6:0], 1'b0} + digit;
  assign sec_next   = {sec_q[4:0], 3'b000} + {sec_q[6:0], 1'b0} + digit;
  assign ssid_raw   = lc_q - p_q;
  assign lc_end     = {1'b0, lc_q} + (LW+1)'(BSSID_CHARS + 1);
  assign rec_ok     = (len_q >= LW'(8)) && pfx_q && (ph_q == PH_REST) && found_q &&
                      (lc_q != p_q) && ((len_q - p_q) >= LW'(REST_MIN)) &&
                      ({1'b0, len_q} == lc_end);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && active_q) begin
          if (action_i == ACT_TICK && timer_inc >= scan_timeout_i) begin
            state_d = ST_ONE;
          end else if (action_i == ACT_BYTE && rx_byte_i == CH_LF &&
                       line_len_q != '0) begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: state_d = (idx_q == stored_q) ? ST_JUDGE : ST_SCAN_CHK;
      ST_SCAN_CHK: state_d = (rb == 8'h00) ? ST_JUDGE : ST_SCAN_RD;
      ST_JUDGE: begin
        if ((len_q == LW'(2) && ok_q) || (len_q == LW'(5) && err_q)) begin
          state_d = ST_ONE;
        end else if (rec_ok && count_q < {{(CNT_W-MAX_W){1'b0}}, max_entries_i}) begin
          state_d = ST_HDR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HDR: state_d = slot_free ? ST_CHAR_RD : ST_HDR;
      ST_CHAR_RD: state_d = ST_CHAR;
      ST_CHAR: begin
        if (slot_free) begin
          state_d = (em_cnt_q == SLEN_W'(1) && !em_ssid_q) ? ST_IDLE : ST_CHAR_RD;
        end
      end
      ST_ONE: state_d = slot_free ? ST_IDLE : ST_ONE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    active_d   = active_q;
    line_len_d = line_len_q;
    stored_d   = stored_q;
    count_d    = count_q;
    timer_d    = timer_q;
    idx_d      = idx_q;
    len_d      = len_q;
    pfx_d      = pfx_q;
    ok_d       = ok_q;
    err_d      = err_q;
    ph_d       = ph_q;
    sig_d      = sig_q;
    sec_d      = sec_q;
    p_d        = p_q;
    lc_d       = lc_q;
    found_d    = found_q;
    slen_d     = slen_q;
    rssi_d     = rssi_q;
    rec_idx_d  = rec_idx_q;
    em_addr_d  = em_addr_q;
    em_cnt_d   = em_cnt_q;
    em_ssid_d  = em_ssid_q;
    one_kind_d = one_kind_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = line_len_q[AW-1:0];
    mem_wdata_o = rx_byte_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    ov_d     = ov_q && !out_ready_i;
    o_kind_d = o_kind_q;
    o_data_d = o_data_q;
    o_rssi_d = o_rssi_q;
    o_sec_d  = o_sec_q;
    o_idx_d  = o_idx_q;
    o_slen_d = o_slen_q;
    o_last_d = o_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_START: begin
              active_d   = 1'b1;
              line_len_d = '0;
              count_d    = '0;
              timer_d    = '0;
            end
            ACT_TICK: begin
              if (active_q) begin
                timer_d = timer_inc;
                if (timer_inc >= scan_timeout_i) begin
                  active_d   = 1'b0;
                  line_len_d = '0;
                  one_kind_d = KIND_TIMEOUT;
                end
              end
            end
            ACT_BYTE: begin
              if (active_q) begin
                if (rx_byte_i == CH_LF) begin
                  line_len_d = '0;
                  stored_d   = line_len_q;
                  idx_d      = '0;
                  pfx_d      = 1'b1;
                  ok_d       = 1'b1;
                  err_d      = 1'b1;
                  ph_d       = PH_SP;
                  sig_d      = '0;
                  sec_d      = '0;
                  found_d    = 1'b0;
                  if (line_len_q != '0) begin
                    timer_d = '0;
                  end
                end else if (rx_byte_i != CH_CR && !rx_byte_i[7] &&
                             line_len_q < LW'(LINE_MAX - 1)) begin
                  mem_we_o   = 1'b1;
                  line_len_d = line_len_q + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (idx_q == stored_q) begin
          len_d = idx_q;
        end else begin
          mem_re_o = 1'b1;
        end
      end
      ST_SCAN_CHK: begin
        if (rb == 8'h00) begin
          len_d = idx_q;
        end else begin
          idx_d = idx_q + 1'b1;
          if (idx_q < LW'(2) && rb != ok_char(idx_q[0])) begin
            ok_d = 1'b0;
          end
          if (idx_q < LW'(5) && rb != error_char(idx_q[2:0])) begin
            err_d = 1'b0;
          end
          if (idx_q < LW'(8)) begin
            if (rb != prefix_char(idx_q[2:0])) begin
              pfx_d = 1'b0;
            end
          end else begin
            case (ph_q)
              PH_SP: begin
                if (rb == CH_SPACE) begin
                  ph_d = PH_SIG;
                end else if (is_digit) begin
                  sig_d = digit;
                  ph_d  = PH_SIG;
                end else if (rb == CH_COMMA) begin
                  ph_d = PH_SEC;
                end else begin
                  ph_d = PH_FAIL;
                end
              end
              PH_SIG: begin
                if (is_digit) begin
                  sig_d = sig_next;
                end else if (rb == CH_COMMA) begin
                  ph_d = PH_SEC;
                end else begin
                  ph_d = PH_FAIL;
                end
              end
              PH_SEC: begin
                if (is_digit) begin
                  sec_d = sec_next;
                end else if (rb == CH_COMMA) begin
                  ph_d = PH_REST;
                  p_d  = idx_q + 1'b1;
                end else begin
                  ph_d = PH_FAIL;
                end
              end
              PH_REST: begin
                if (rb == CH_COMMA) begin
                  lc_d    = idx_q;
                  found_d = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_JUDGE: begin
        if (len_q == LW'(2) && ok_q) begin
          active_d   = 1'b0;
          one_kind_d = KIND_DONE;
        end else if (len_q == LW'(5) && err_q) begin
          active_d   = 1'b0;
          one_kind_d = KIND_ERROR;
        end else if (rec_ok) begin
          rssi_d    = sig_q - RSSI_OFFSET;
          rec_idx_d = count_q;
          if ({1'b0, ssid_raw} > (LW+1)'(SSID_MAX)) begin
            slen_d = SLEN_W'(SSID_MAX);
          end else begin
            slen_d = SLEN_W'(ssid_raw);
          end
          if (count_q != CNT_TOP) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          ov_d      = 1'b1;
          o_kind_d  = KIND_HDR;
          o_data_d  = '0;
          o_rssi_d  = rssi_q;
          o_sec_d   = sec_q;
          o_idx_d   = rec_idx_q;
          o_slen_d  = slen_q;
          o_last_d  = 1'b0;
          em_addr_d = p_q[AW-1:0];
          em_cnt_d  = slen_q;
          em_ssid_d = 1'b1;
        end
      end
      ST_CHAR_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = em_addr_q;
      end
      ST_CHAR: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          o_kind_d = em_ssid_q ? KIND_SSID : KIND_BSSID;
          o_data_d = rb;
          o_rssi_d = rssi_q;
          o_sec_d  = sec_q;
          o_idx_d  = rec_idx_q;
          o_slen_d = slen_q;
          o_last_d = !em_ssid_q && (em_cnt_q == SLEN_W'(1));
          if (em_cnt_q == SLEN_W'(1) && em_ssid_q) begin
            em_ssid_d = 1'b0;
            em_addr_d = lc_q[AW-1:0] + 1'b1;
            em_cnt_d  = SLEN_W'(BSSID_CHARS);
          end else begin
            em_addr_d = em_addr_q + 1'b1;
            em_cnt_d  = em_cnt_q - 1'b1;
          end
        end
      end
      ST_ONE: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          o_kind_d = one_kind_q;
          o_data_d = '0;
          o_rssi_d = '0;
          o_sec_d  = '0;
          o_idx_d  = (one_kind_q == KIND_ERROR) ? '0 : count_q;
          o_slen_d = '0;
          o_last_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      active_q   <= 1'b0;
      line_len_q <= '0;
      count_q    <= '0;
      timer_q    <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      line_len_q <= line_len_d;
      count_q    <= count_d;
      timer_q    <= timer_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stored_q   <= stored_d;
    idx_q      <= idx_d;
    len_q      <= len_d;
    pfx_q      <= pfx_d;
    ok_q       <= ok_d;
    err_q      <= err_d;
    ph_q       <= ph_d;
    sig_q      <= sig_d;
    sec_q      <= sec_d;
    p_q        <= p_d;
    lc_q       <= lc_d;
    found_q    <= found_d;
    slen_q     <= slen_d;
    rssi_q     <= rssi_d;
    rec_idx_q  <= rec_idx_d;
    em_addr_q  <= em_addr_d;
    em_cnt_q   <= em_cnt_d;
    em_ssid_q  <= em_ssid_d;
    one_kind_q <= one_kind_d;
    o_kind_q   <= o_kind_d;
    o_data_q   <= o_data_d;
    o_rssi_q   <= o_rssi_d;
    o_sec_q    <= o_sec_d;
    o_idx_q    <= o_idx_d;
    o_slen_q   <= o_slen_d;
    o_last_q   <= o_last_d;
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = o_kind_q;
  assign data_byte_o   = o_data_q;
  assign rssi_dbm_o    = o_rssi_q;
  assign security_o    = o_sec_q;
  assign ap_index_o    = o_idx_q;
  assign ssid_length_o = o_slen_q;
  assign last_o        = o_last_q;

endmodule

FILE: rtl/wifi_scan_reply_parser_top.sv
// ----------------------------------------------------------------------------
// Wi-Fi scan reply parser
// Turns the text reply of a Wi-Fi module's scan command into records.
// ----------------------------------------------------------------------------
// The input channel carries received bytes, millisecond ticks and scan start
// commands. The output channel carries record headers, SSID and BSSID
// characters and the done, error and timeout events; last marks the final
// result caused by one input transfer.
// A byte that does not end a line and a start are taken in the idle state. A
// tick that produces a timeout event also passes through the event state. A
// line feed starts a walk of the stored line through the line memory, with a
// read state and a check state for each byte, paced by the single read port
// with its registered output. A record then takes a read state and an emit
// state for each character, again paced by that read port.
// One item is in work at a time; input ready is high only when the engine is
// idle, and a finished result waits in the output register.
// Reset clears the line, the scan state, the counters and the output valid flag
// and loads the register defaults; no clearing pass over the memory is needed.
// A stalled receiver holds the engine on the pending result.
// ----------------------------------------------------------------------------
module wifi_scan_reply_parser_top #(
  parameter int LINE_MAX = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   kind_o,
  output logic [7:0]                   data_byte_o,
  output logic signed [7:0]            rssi_dbm_o,
  output logic [7:0]                   security_o,
  output logic [wsrp_pkg::CNT_W-1:0]   ap_index_o,
  output logic [wsrp_pkg::SLEN_W-1:0]  ssid_length_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [wsrp_pkg::CFG_W-1:0]   cfg_data_i
);

  import wsrp_pkg::*;

  localparam int DEPTH = LINE_MAX - 1;
  localparam int AW    = $clog2(LINE_MAX - 1);
  localparam int LW    = $clog2(LINE_MAX);

  logic [TIMER_W-1:0] timeout_q;
  logic [MAX_W-1:0]   max_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      max_q     <= MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i[TIMER_W-1:0];
        CFG_MAX:     max_q     <= cfg_data_i[MAX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wsrp_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wsrp_engine #(
    .LINE_MAX (LINE_MAX),
    .AW       (AW),
    .LW       (LW)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .rx_byte_i      (rx_byte_i),
    .scan_timeout_i (timeout_q),
    .max_entries_i  (max_q),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .rssi_dbm_o     (rssi_dbm_o),
    .security_o     (security_o),
    .ap_index_o     (ap_index_o),
    .ssid_length_o  (ssid_length_o),
    .last_o         (last_o)
  );

endmodule

FILE: rtl/wsrp_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports and checks the result stream.
// ----------------------------------------------------------------------------
`include "wifi_scan_reply_parser_top_macros.svh"

module wsrp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [2:0]                   kind_o,
  input logic [wsrp_pkg::CNT_W-1:0]   ap_index_o,
  input logic                         last_o
);

  import wsrp_pkg::*;

  logic is_event;

  assign is_event = (kind_o == KIND_DONE) || (kind_o == KIND_ERROR) ||
                    (kind_o == KIND_TIMEOUT);

  `WSRP_ASSERT_STD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `WSRP_ASSERT_STD(a_event_last, out_valid_o && is_event |-> last_o)
  `WSRP_ASSERT_STD(a_hdr_not_last, out_valid_o && kind_o == KIND_HDR |-> !last_o)
  `WSRP_ASSERT_STD(a_error_index, out_valid_o && kind_o == KIND_ERROR |-> ap_index_o == '0)

endmodule

bind wifi_scan_reply_parser_top wsrp_checker u_wsrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .ap_index_o  (ap_index_o),
  .last_o      (last_o)
);
